// ===== design/lbs_pkg.sv =====
`timescale 1ns / 1ps

package lbs_pkg;

    // Table geometry.
    localparam int BONE_COUNT = 64;
    localparam int INFLUENCES = 4;
    localparam int LANES      = 4;
    localparam int ELEMS      = 12;
    localparam int BONE_W     = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;
    localparam int ELEM_W     = 4;

    // Datapath widths.
    localparam int PROD_W = 64;
    localparam int SUM_W  = 66;
    localparam int LO_W   = 33;
    localparam int HI_W   = SUM_W - LO_W;
    localparam int WGT_W  = 16;
    localparam int ACC_W  = 86;
    localparam int FRAC_SHIFT = 31;
    localparam int LANE_LAT   = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SKIN = 1'b1;

    typedef logic [BONE_W-1:0] bone_addr_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         bone_a;
        logic [5:0]         bone_b;
        logic [5:0]         bone_c;
        logic [5:0]         bone_d;
        logic [15:0]        weight_a;
        logic [15:0]        weight_b;
        logic [15:0]        weight_c;
        logic [15:0]        weight_d;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               saturated;
    } out_word_t;

    // One element write into the bone tables.
    typedef struct packed {
        logic              we;
        bone_addr_t        bone;
        logic [ELEM_W-1:0] elem;
        logic [31:0]       data;
    } wr_t;

endpackage

// ===== design/lbs_lane.sv =====
`timescale 1ns / 1ps

module lbs_lane (
    input  logic                              clk,
    input  logic                              adv,
    input  lbs_pkg::wr_t                      wr,
    input  lbs_pkg::bone_addr_t               rd_addr,
    input  logic                              enable,
    input  logic [lbs_pkg::WGT_W-1:0]         weight,
    input  logic signed [2:0][31:0]           vertex,
    output lbs_pkg::acc_t                     term [3]
);

    // Private copy of the bone table, one row of twelve elements per bone.
    logic [lbs_pkg::ELEMS-1:0][31:0] mem [lbs_pkg::BONE_COUNT];

    logic [lbs_pkg::ELEMS-1:0][31:0] row_reg;
    logic                            en_reg;
    logic [lbs_pkg::WGT_W-1:0]       w1_reg, w2_reg, w3_reg;
    logic signed [2:0][31:0]         v_reg;

    logic signed [lbs_pkg::PROD_W-1:0] prod_reg [3][3];
    logic signed [31:0]                trans_reg [3];
    logic signed [lbs_pkg::SUM_W-1:0]  rsum_reg [3];
    logic [lbs_pkg::LO_W+lbs_pkg::WGT_W-1:0]        plo_reg [3];
    logic signed [lbs_pkg::HI_W+lbs_pkg::WGT_W:0]   phi_reg [3];
    lbs_pkg::acc_t                                  term_reg [3];

    logic [lbs_pkg::ELEMS-1:0][31:0] row_used;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.bone][wr.elem] <= wr.data;
        end
        if (adv)
        begin
            row_reg <= mem[rd_addr];
            en_reg  <= enable;
            w1_reg  <= weight;
            v_reg   <= vertex;
        end
    end

    // A lane that takes no part contributes a zero matrix.
    assign row_used = en_reg ? row_reg : '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= signed'(row_used[r*4+c]) * signed'(v_reg[c]);
                end
                trans_reg[r] <= signed'(row_used[r*4+3]);
                rsum_reg[r]  <= lbs_pkg::SUM_W'(prod_reg[r][0])
                              + lbs_pkg::SUM_W'(prod_reg[r][1])
                              + lbs_pkg::SUM_W'(prod_reg[r][2])
                              + (lbs_pkg::SUM_W'(trans_reg[r]) <<< 16);
                plo_reg[r]   <= rsum_reg[r][lbs_pkg::LO_W-1:0] * w3_reg;
                phi_reg[r]   <= signed'(rsum_reg[r][lbs_pkg::SUM_W-1:lbs_pkg::LO_W])
                              * signed'({1'b0, w3_reg});
                term_reg[r]  <= (lbs_pkg::ACC_W'(phi_reg[r]) <<< lbs_pkg::LO_W)
                              + lbs_pkg::ACC_W'(plo_reg[r]);
            end
        end
    end

    assign term = term_reg;

endmodule

// ===== design/lbs_merge.sv =====
`timescale 1ns / 1ps

module lbs_merge (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                valid_in,
    input  lbs_pkg::acc_t       terms [lbs_pkg::LANES][3],
    output lbs_pkg::out_word_t  out_word,
    output logic                out_valid
);

    localparam int SH_W = lbs_pkg::ACC_W - lbs_pkg::FRAC_SHIFT;
    localparam logic signed [SH_W-1:0] MAX_V = SH_W'(32'sh7FFF_FFFF);
    localparam logic signed [SH_W-1:0] MIN_V = -(SH_W'(32'sh7FFF_FFFF)) - SH_W'(1);

    lbs_pkg::acc_t      sum_reg [3];
    logic               sv_reg;
    logic               out_valid_reg;
    lbs_pkg::out_word_t out_reg, out_next;

    lbs_pkg::acc_t          rnd [3];
    logic signed [SH_W-1:0] sh [3];
    logic signed [31:0]     clamped [3];
    logic [2:0]             sat;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            rnd[r] = sum_reg[r] + (lbs_pkg::ACC_W'(1) <<< (lbs_pkg::FRAC_SHIFT - 1));
            sh[r]  = rnd[r][lbs_pkg::ACC_W-1:lbs_pkg::FRAC_SHIFT];
            sat[r] = (sh[r] > MAX_V) || (sh[r] < MIN_V);
            if (sh[r] > MAX_V)
                clamped[r] = 32'sh7FFF_FFFF;
            else if (sh[r] < MIN_V)
                clamped[r] = 32'sh8000_0000;
            else
                clamped[r] = sh[r][31:0];
        end
        out_next.out_x     = clamped[0];
        out_next.out_y     = clamped[1];
        out_next.out_z     = clamped[2];
        out_next.saturated = |sat;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= terms[0][r] + terms[1][r] + terms[2][r] + terms[3][r];
            end
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv_reg        <= valid_in;
            out_valid_reg <= sv_reg;
        end
    end

    assign out_word  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== design/linear_blend_skinning.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+----------------------------
// in       | input     | in_valid / in_ready  | in_data  (lbs_pkg::in_word_t)
// out      | output    | out_valid / out_ready| out_data (lbs_pkg::out_word_t)
//
// One word is accepted every cycle while the output side takes results.
// A skin word passes to its result through one table read, four lane stages
// (products, row sum, weight partial products, their recombination) and two
// merge stages (lane sum, rounding with saturation into the output register).
// Load words give no result. Reset clears only the valid pipeline; the bone
// tables hold nothing defined until written. A stalled output freezes the
// whole pipeline, and in_ready then stays low until the result is taken.

module linear_blend_skinning (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lbs_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lbs_pkg::out_word_t out_data
);

    logic adv;
    logic accept;
    logic load_ok;
    lbs_pkg::wr_t wr;

    logic [lbs_pkg::LANE_LAT-1:0] vpipe_reg;

    logic [5:0]                bones   [lbs_pkg::LANES];
    logic [lbs_pkg::WGT_W-1:0] weights [lbs_pkg::LANES];
    logic signed [2:0][31:0]   vertex;
    lbs_pkg::acc_t             terms [lbs_pkg::LANES][3];

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;

    // A load writes one element into every lane's copy of the table; loads to
    // a bone or element beyond the table are dropped.
    assign load_ok  = (32'(in_data.bone_a) < lbs_pkg::BONE_COUNT)
                   && (32'(in_data.bone_b) < lbs_pkg::ELEMS);
    assign wr.we    = accept && (in_data.opcode == lbs_pkg::OP_LOAD) && load_ok;
    assign wr.bone  = lbs_pkg::BONE_W'(in_data.bone_a);
    assign wr.elem  = in_data.bone_b[lbs_pkg::ELEM_W-1:0];
    assign wr.data  = in_data.pos_x;

    assign bones[0]   = in_data.bone_a;
    assign bones[1]   = in_data.bone_b;
    assign bones[2]   = in_data.bone_c;
    assign bones[3]   = in_data.bone_d;
    assign weights[0] = in_data.weight_a;
    assign weights[1] = in_data.weight_b;
    assign weights[2] = in_data.weight_c;
    assign weights[3] = in_data.weight_d;
    assign vertex     = {in_data.pos_z, in_data.pos_y, in_data.pos_x};

    // Each lane blends one bone influence; a lane beyond the influence count
    // or holding a bone outside the table adds nothing.
    for (genvar k = 0; k < lbs_pkg::LANES; k++)
    begin : g_lane
        logic lane_en;
        assign lane_en = (k < lbs_pkg::INFLUENCES)
                      && (32'(bones[k]) < lbs_pkg::BONE_COUNT);
        lbs_lane u_lane (
            .clk     (clk),
            .adv     (adv),
            .wr      (wr),
            .rd_addr (lbs_pkg::BONE_W'(bones[k])),
            .enable  (lane_en),
            .weight  (weights[k]),
            .vertex  (vertex),
            .term    (terms[k])
        );
    end

    // Marks which lane stages carry a skin word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '0;
        end
        else if (adv)
        begin
            vpipe_reg <= {vpipe_reg[lbs_pkg::LANE_LAT-2:0],
                          in_valid && (in_data.opcode == lbs_pkg::OP_SKIN)};
        end
    end

    lbs_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .valid_in  (vpipe_reg[lbs_pkg::LANE_LAT-1]),
        .terms     (terms),
        .out_word  (out_data),
        .out_valid (out_valid)
    );

endmodule

// ===== design/lbs_checker.sv =====
`timescale 1ns / 1ps

module lbs_assertions (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input lbs_pkg::out_word_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    a_sat_clamps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |->
            out_data.out_x == 32'sh7FFF_FFFF || out_data.out_x == 32'sh8000_0000 ||
            out_data.out_y == 32'sh7FFF_FFFF || out_data.out_y == 32'sh8000_0000 ||
            out_data.out_z == 32'sh7FFF_FFFF || out_data.out_z == 32'sh8000_0000)
        else $error("saturation flag without a clamped coordinate");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with an empty output register");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while results are being taken");

endmodule

bind linear_blend_skinning lbs_assertions u_lbs_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
